[src/fircd_pkg.sv]
// Shared types and constants for the circular-delay FIR filter.
package fircd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DIGIT_W  = 4;
    localparam int DIGITS   = SAMPLE_W / DIGIT_W;
    localparam int PP_W     = SAMPLE_W + DIGIT_W + 1;
    localparam int PROD_W   = 2 * SAMPLE_W;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [5:0]                 coef_index;
        logic signed [SAMPLE_W-1:0] coef_value;
    } fircd_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_sample;
        logic                       saturated;
    } fircd_out_t;

    typedef struct packed {
        logic clr;    // zero accumulator and partial product
        logic load;   // take new coefficient and sample, restart partial product
        logic step;   // one radix-16 digit step
        logic first;  // current digit is the signed top digit
        logic add;    // fold partial product into accumulator
    } fircd_mac_ctl_t;

endpackage

[src/fircd_mac.sv]
// Digit-serial multiply-accumulate unit: one 4-bit sample digit per cycle while step is set, MSB first.
module fircd_mac
    import fircd_pkg::*;
#(
    parameter int ACC_W = 39
)
(
    input  logic                       clk,
    input  fircd_mac_ctl_t             ctl,
    input  logic signed [SAMPLE_W-1:0] coef,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [SAMPLE_W-1:0] coef_reg;
    logic [SAMPLE_W-1:0]        samp_sh_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    logic signed [SAMPLE_W-1:0] coef_next;
    logic [SAMPLE_W-1:0]        samp_sh_next;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc_next;

    logic signed [DIGIT_W:0]    digit;
    logic signed [PP_W-1:0]     pp;

    // top digit carries the sign, lower digits are unsigned
    assign digit = ctl.first ? {samp_sh_reg[SAMPLE_W-1], samp_sh_reg[SAMPLE_W-1 -: DIGIT_W]}
                             : {1'b0, samp_sh_reg[SAMPLE_W-1 -: DIGIT_W]};
    assign pp    = coef_reg * digit;

    always_comb
    begin
        coef_next    = coef_reg;
        samp_sh_next = samp_sh_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        if (ctl.add)
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (ctl.clr)
        begin
            acc_next  = '0;
            prod_next = '0;
        end
        else if (ctl.load)
        begin
            coef_next    = coef;
            samp_sh_next = sample;
            prod_next    = '0;
        end
        else if (ctl.step)
        begin
            prod_next    = (prod_reg <<< DIGIT_W) + {{(PROD_W-PP_W){pp[PP_W-1]}}, pp};
            samp_sh_next = samp_sh_reg << DIGIT_W;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg    <= coef_next;
        samp_sh_reg <= samp_sh_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[src/fir_filter_circular_delay.sv]
// FIR filter with circular delay line: a filter request passes ST_RD, then ST_LD and ST_MUL
// for each tap, then ST_SUM and ST_FIN; no new request is taken until it is back in idle.
// Each tap costs a load state plus four radix-16 steps of the shared 16x5 multiplier.
// A coefficient load request is written while idle and returns nothing.
// Reset clears the per-entry valid bits, so delay line and coefficients read as zero,
// and the write pointer; no clearing pass is needed.
module fir_filter_circular_delay
    import fircd_pkg::*;
#(
    parameter int TAPS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  fircd_in_t  item,
    output logic       result_valid,
    input  logic       result_ready,
    output fircd_out_t result
);

    localparam int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int ACC_W = 33 + $clog2(TAPS);
    localparam int Q_W   = ACC_W - 15;
    localparam int DIG_W = $clog2(DIGITS);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TAPS - 1);
    localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(DIGITS - 1);

    localparam logic signed [Q_W-1:0]   Q_MAX     = Q_W'(32767);
    localparam logic signed [Q_W-1:0]   Q_MIN     = -Q_W'(32768);
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'(32767);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_LD   = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] pos_reg, pos_next;
    logic [PTR_W-1:0] tap_reg, tap_next;
    logic [DIG_W-1:0] dig_reg, dig_next;
    logic             last_reg, last_next;
    logic             res_valid_reg, res_valid_next;
    fircd_out_t       res_reg, res_next;

    logic [TAPS-1:0]  coef_vld_reg, coef_vld_next;
    logic [TAPS-1:0]  dly_vld_reg, dly_vld_next;

    logic signed [SAMPLE_W-1:0] coef_mem [TAPS];
    logic signed [SAMPLE_W-1:0] dly_mem  [TAPS];
    logic signed [SAMPLE_W-1:0] coef_rd_reg, dly_rd_reg;
    logic                       coef_rv_reg, dly_rv_reg;

    logic             accept;
    logic             coef_we, dly_we;
    logic [PTR_W-1:0] coef_waddr;

    fircd_mac_ctl_t             mac_ctl;
    logic signed [ACC_W-1:0]    acc;
    logic signed [SAMPLE_W-1:0] mac_coef, mac_sample;
    logic signed [ACC_W-1:0]    biased;
    logic signed [Q_W-1:0]      q;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign coef_we    = accept && (item.op == OP_LOAD) && (int'(item.coef_index) < TAPS);
    assign dly_we     = accept && (item.op == OP_FILTER);
    assign coef_waddr = PTR_W'(item.coef_index);

    assign mac_coef   = coef_rv_reg ? coef_rd_reg : '0;
    assign mac_sample = dly_rv_reg ? dly_rd_reg : '0;

    // divide by 2^15 truncating toward zero
    assign biased = acc + (acc[ACC_W-1] ? TRUNC_BIAS : '0);
    assign q      = $signed(biased[ACC_W-1:15]);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        pos_next       = pos_reg;
        tap_next       = tap_reg;
        dig_next       = dig_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        coef_vld_next  = coef_vld_reg;
        dly_vld_next   = dly_vld_reg;
        mac_ctl        = '0;

        if (coef_we)
        begin
            coef_vld_next[coef_waddr] = 1'b1;
        end
        if (dly_we)
        begin
            dly_vld_next[wp_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (dly_we)
                begin
                    mac_ctl.clr = 1'b1;
                    pos_next    = wp_reg;
                    tap_next    = '0;
                    wp_next     = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                    state_next  = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_LD;
            end
            ST_LD:
            begin
                mac_ctl.load = 1'b1;
                mac_ctl.add  = 1'b1;
                dig_next     = '0;
                last_next    = (tap_reg == PTR_LAST);
                // advance addresses now so the next tap is read during the digit steps
                if (tap_reg != PTR_LAST)
                begin
                    tap_next = tap_reg + 1'b1;
                    pos_next = (pos_reg == '0) ? PTR_LAST : pos_reg - 1'b1;
                end
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mac_ctl.step  = 1'b1;
                mac_ctl.first = (dig_reg == '0);
                dig_next      = dig_reg + 1'b1;
                if (dig_reg == DIG_LAST)
                begin
                    state_next = last_reg ? ST_SUM : ST_LD;
                end
            end
            ST_SUM:
            begin
                mac_ctl.add = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    priority if (q > Q_MAX)
                    begin
                        res_next.filtered_sample = 16'sh7fff;
                        res_next.saturated       = 1'b1;
                    end
                    else if (q < Q_MIN)
                    begin
                        res_next.filtered_sample = 16'sh8000;
                        res_next.saturated       = 1'b1;
                    end
                    else
                    begin
                        res_next.filtered_sample = q[SAMPLE_W-1:0];
                        res_next.saturated       = 1'b0;
                    end
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            res_valid_reg <= 1'b0;
            coef_vld_reg  <= '0;
            dly_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            res_valid_reg <= res_valid_next;
            coef_vld_reg  <= coef_vld_next;
            dly_vld_reg   <= dly_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        tap_reg  <= tap_next;
        dig_reg  <= dig_next;
        last_reg <= last_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= item.coef_value;
        end
        coef_rd_reg <= coef_mem[tap_reg];
        coef_rv_reg <= coef_vld_reg[tap_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dly_we)
        begin
            dly_mem[wp_reg] <= item.sample_in;
        end
        dly_rd_reg <= dly_mem[pos_reg];
        dly_rv_reg <= dly_vld_reg[pos_reg];
    end

    fircd_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .ctl    (mac_ctl),
        .coef   (mac_coef),
        .sample (mac_sample),
        .acc    (acc)
    );

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

[src/fircd_chk.sv]
// Port-level checker for the circular-delay FIR filter, bound to the top level.
module fircd_chk
    import fircd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input fircd_in_t  item,
    input logic       result_valid,
    input logic       result_ready,
    input fircd_out_t result
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before accept");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("stalled result changed");

    // clipping only reports at the range limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.filtered_sample == 16'sh7fff || result.filtered_sample == 16'sh8000))
        else $error("saturated flag without clipped value");

    // nothing is in flight when an idle block takes a request, and no request answers at once
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !result_valid |=> !result_valid)
        else $error("result appeared one cycle after request");

endmodule

bind fir_filter_circular_delay fircd_chk u_fircd_chk (.*);
